// ===== rtl/dnsd_pkg.sv =====
// Shared types and constants for the DAB null symbol detector.
// Holds field widths, configuration reset values and the command and status
// structs between the controller and the datapath. Depends on nothing.
package dnsd_pkg;

    // Field and port widths.
    localparam int MAG_W   = 16;
    localparam int CFG_W   = 13;
    localparam int CFG_MAX = (2 ** CFG_W) - 1;
    localparam int LEVEL_W = 33;
    localparam int SUM_W   = 32;
    localparam int IDX_W   = 16;
    localparam int DIP_W   = 16;
    localparam int PHASE_W = 3;
    localparam int ADDR_W  = 3;
    localparam int PDATA_W = 32;
    localparam int SDATA_W = 16;
    localparam int SUSER_W = 1;
    localparam int MDATA_W = 8;

    // Default build parameters.
    localparam int WINDOW_LEN_DEF   = 50;
    localparam int LEVEL_SHIFT_DEF  = 17;
    localparam int INIT_SYMBOLS_DEF = 10;

    // Configuration register reset values.
    localparam logic [CFG_W-1:0] SYMBOL_LENGTH_RST = 13'd2552;
    localparam logic [CFG_W-1:0] NULL_LENGTH_RST   = 13'd2656;

    // Configuration register index, taken from the word offset.
    typedef enum logic {
        REG_SYMBOL_LENGTH = 1'b0,
        REG_NULL_LENGTH   = 1'b1
    } reg_idx_t;

    // Search phase reported in every result transaction.
    typedef enum logic [PHASE_W-1:0] {
        PH_INIT  = 3'd0,
        PH_FILL  = 3'd1,
        PH_DIP   = 3'd2,
        PH_END   = 3'd3,
        PH_FOUND = 3'd4
    } phase_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // capture the accepted input transaction
        logic init_acc;      // add the magnitude to the initial sum
        logic level_track;   // exponential level update
        logic fill_step;     // write the window, total grows
        logic slide_step;    // replace the oldest window entry
        logic dip_inc;       // saturating dip counter increment
        logic dip_clear;     // clear the dip counter
        logic clear_window;  // clear window total, sample index and position
        logic div_start;     // start the initial mean division
        logic level_load;    // load the level from the division result
    } dnsd_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic func;          // captured restart flag
        logic init_done;     // enough initial samples taken
        logic fill_done;     // window holds a full run of samples
        logic dip_timeout;   // dip search ran too long
        logic end_timeout;   // end search ran too long
        logic dip_met;       // window level at most half the long-term level
        logic end_met;       // window level at least 3/4 of the long-term level
        logic div_done;      // division result is ready
    } dnsd_stat_t;

endpackage

// ===== rtl/dnsd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the sliding window store. Depends on nothing.
module dnsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/dnsd_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Computes the initial mean level. Depends on nothing.
module dnsd_divider #(
    parameter int DVD_W = 49,
    parameter int DSR_W = 17
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             fits;

    // One trial subtraction per cycle.
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    // Iteration control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DVD_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // A new division always withdraws the previous result.
    a_start_clears_done: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !done_reg)
        else $error("divider result still flagged after a new start");

endmodule

// ===== rtl/dnsd_datapath.sv =====
// Datapath of the null symbol detector: long-term level, initial sum,
// window store and total, counters, threshold tests and the mean divider.
// Depends on dnsd_pkg, dnsd_ram and dnsd_divider.
module dnsd_datapath #(
    parameter int WINDOW_LEN   = dnsd_pkg::WINDOW_LEN_DEF,
    parameter int LEVEL_SHIFT  = dnsd_pkg::LEVEL_SHIFT_DEF,
    parameter int INIT_SYMBOLS = dnsd_pkg::INIT_SYMBOLS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          func_in,
    input  logic [dnsd_pkg::MAG_W-1:0]    mag_in,
    input  logic [dnsd_pkg::CFG_W-1:0]    symbol_length,
    input  logic [dnsd_pkg::CFG_W-1:0]    null_length,
    input  dnsd_pkg::dnsd_cmd_t           cmd,
    output dnsd_pkg::dnsd_stat_t          stat
);

    import dnsd_pkg::*;

    localparam int POS_W = $clog2(WINDOW_LEN);
    localparam int TOT_W = MAG_W + POS_W;
    localparam int CNT_W = $clog2(INIT_SYMBOLS * CFG_MAX + 2);
    localparam int DVD_W = SUM_W + LEVEL_SHIFT;
    localparam int LHS_W = TOT_W + LEVEL_SHIFT + 2;
    localparam int RHS_W = LEVEL_W + $clog2(3 * WINDOW_LEN + 1);
    localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam int LIM_W = CFG_W + 2;

    logic               func_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic [SUM_W-1:0]   init_sum_reg;
    logic [SUM_W-1:0]   init_sum_next;
    logic [CNT_W-1:0]   init_cnt_reg;
    logic [TOT_W-1:0]   total_reg;
    logic [TOT_W-1:0]   total_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [DIP_W-1:0]   dip_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [MAG_W-1:0]   ring_rd;
    logic               ring_wr;
    logic [SUM_W:0]     init_sum_wide;
    logic [LEVEL_W:0]   level_wide;
    logic [CNT_W-1:0]   init_target;
    logic [LIM_W-1:0]   end_limit;
    logic [CMP_W-1:0]   dip_lhs;
    logic [CMP_W-1:0]   dip_rhs;
    logic [CMP_W-1:0]   end_lhs;
    logic [CMP_W-1:0]   end_rhs;
    logic [DVD_W-1:0]   dividend;
    logic [DVD_W-1:0]   quotient;
    logic               div_done;

    // Input capture on acceptance.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= func_in;
            mag_reg  <= mag_in;
        end
    end

    // Saturating initial sum and tracked level.
    assign init_sum_wide = {1'b0, init_sum_reg} + (SUM_W + 1)'(mag_reg);
    assign init_sum_next = init_sum_wide[SUM_W] ? '1 : init_sum_wide[SUM_W-1:0];
    assign level_wide    = {1'b0, level_reg} - {1'b0, (level_reg >> LEVEL_SHIFT)}
                         + (LEVEL_W + 1)'(mag_reg);

    always_comb begin
        level_next = level_reg;
        if (cmd.level_load) begin
            level_next = (|quotient[DVD_W-1:LEVEL_W]) ? '1 : quotient[LEVEL_W-1:0];
        end else if (cmd.level_track) begin
            level_next = level_wide[LEVEL_W] ? '1 : level_wide[LEVEL_W-1:0];
        end
    end

    // Window total: cleared on a window clear, grows while filling, slides afterwards.
    always_comb begin
        total_next = total_reg;
        if (cmd.clear_window) begin
            total_next = '0;
        end else if (cmd.fill_step) begin
            total_next = total_reg + TOT_W'(mag_reg);
        end else if (cmd.slide_step) begin
            total_next = total_reg - TOT_W'(ring_rd) + TOT_W'(mag_reg);
        end
    end

    assign pos_next = (pos_reg == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_reg + 1'b1;
    assign ring_wr  = cmd.fill_step | cmd.slide_step;

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg    <= '0;
            init_sum_reg <= '0;
            init_cnt_reg <= '0;
            total_reg    <= '0;
            idx_reg      <= '0;
            dip_reg      <= '0;
            pos_reg      <= '0;
        end else begin
            level_reg <= level_next;
            total_reg <= total_next;
            if (cmd.init_acc) begin
                init_sum_reg <= init_sum_next;
                init_cnt_reg <= init_cnt_reg + 1'b1;
            end
            if (cmd.clear_window) begin
                idx_reg <= '0;
                pos_reg <= '0;
            end else if (ring_wr) begin
                idx_reg <= idx_reg + 1'b1;
                pos_reg <= pos_next;
            end
            if (cmd.dip_clear) begin
                dip_reg <= '0;
            end else if (cmd.dip_inc && (dip_reg != '1)) begin
                dip_reg <= dip_reg + 1'b1;
            end
        end
    end

    // Sliding window store.
    dnsd_ram #(
        .WIDTH (MAG_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_wr),
        .wr_addr (pos_reg),
        .wr_data (mag_reg),
        .rd_addr (pos_reg),
        .rd_data (ring_rd)
    );

    // Initial mean: sum scaled to the level's fraction bits over the count.
    assign dividend = DVD_W'(init_sum_reg) << LEVEL_SHIFT;

    dnsd_divider #(
        .DVD_W (DVD_W),
        .DSR_W (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (init_cnt_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Threshold tests on the registered level and window total.
    assign init_target = CNT_W'(INIT_SYMBOLS) * CNT_W'(symbol_length);
    assign end_limit   = LIM_W'({symbol_length, 1'b0}) + LIM_W'(null_length);
    assign dip_lhs     = CMP_W'(total_reg) << (LEVEL_SHIFT + 1);
    assign dip_rhs     = CMP_W'(level_reg) * CMP_W'(WINDOW_LEN);
    assign end_lhs     = CMP_W'(total_reg) << (LEVEL_SHIFT + 2);
    assign end_rhs     = CMP_W'(level_reg) * CMP_W'(3 * WINDOW_LEN);

    always_comb begin
        stat.func        = func_reg;
        stat.init_done   = (init_cnt_reg >= init_target);
        stat.fill_done   = (idx_reg >= IDX_W'(WINDOW_LEN));
        stat.dip_timeout = (dip_reg > DIP_W'({symbol_length, 1'b0}));
        stat.end_timeout = (idx_reg > IDX_W'(end_limit));
        stat.dip_met     = (dip_lhs <= dip_rhs);
        stat.end_met     = (end_lhs >= end_rhs);
        stat.div_done    = div_done;
    end

    // The window position never leaves the window.
    a_pos_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(WINDOW_LEN - 1))
        else $error("window position outside the window");

endmodule

// ===== rtl/dnsd_ctrl.sv =====
// Controller of the null symbol detector: item sequencing, search phase,
// sync flag and the result register. Depends on dnsd_pkg.
module dnsd_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dnsd_pkg::PHASE_W-1:0]   m_phase,
    output logic                           m_null_end,
    output logic                           m_timed_out,
    output logic                           m_synced,
    output dnsd_pkg::dnsd_cmd_t            cmd,
    input  dnsd_pkg::dnsd_stat_t           stat
);

    import dnsd_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_TEST   = 4'b0100,
        ST_DIVIDE = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    logic               synced_reg, synced_next;
    logic               m_valid_reg, m_valid_next;
    logic [PHASE_W-1:0] out_phase_reg, out_phase_next;
    logic               out_end_reg, out_end_next;
    logic               out_to_reg, out_to_next;
    logic               out_sync_reg, out_sync_next;
    logic               can_emit;
    logic               emit;
    logic               pulse_end;
    logic               pulse_to;

    assign can_emit = !m_valid_reg || m_tready;

    // Item sequencing and phase decisions.
    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        synced_next = synced_reg;
        cmd         = '0;
        emit        = 1'b0;
        pulse_end   = 1'b0;
        pulse_to    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // Window data for the current position is valid now.
                if (!stat.func) begin
                    if (phase_reg == PH_INIT) begin
                        cmd.init_acc = 1'b1;
                    end else begin
                        cmd.level_track = 1'b1;
                        case (phase_reg)
                            PH_FILL: cmd.fill_step = 1'b1;
                            PH_DIP: begin
                                cmd.slide_step = 1'b1;
                                cmd.dip_inc    = 1'b1;
                            end
                            PH_END:  cmd.slide_step = 1'b1;
                            default: ;
                        endcase
                    end
                end
                state_next = ST_TEST;
            end
            ST_TEST: begin
                if (can_emit) begin
                    emit = 1'b1;
                    if (stat.func) begin
                        // Restart is ignored until the level is established.
                        if (phase_reg != PH_INIT) begin
                            cmd.clear_window = 1'b1;
                            phase_next       = PH_FILL;
                        end
                    end else begin
                        unique case (phase_reg)
                            PH_INIT: begin
                                if (stat.init_done) begin
                                    cmd.div_start = 1'b1;
                                    emit          = 1'b0;
                                end
                            end
                            PH_FILL: begin
                                if (stat.fill_done) begin
                                    cmd.dip_clear = 1'b1;
                                    synced_next   = 1'b0;
                                    phase_next    = PH_DIP;
                                    if (stat.dip_met) begin
                                        phase_next = PH_END;
                                        if (stat.end_met) begin
                                            phase_next  = PH_FOUND;
                                            synced_next = 1'b1;
                                            pulse_end   = 1'b1;
                                        end
                                    end
                                end
                            end
                            PH_DIP: begin
                                if (stat.dip_timeout) begin
                                    cmd.clear_window = 1'b1;
                                    phase_next       = PH_FILL;
                                    pulse_to         = 1'b1;
                                end else if (stat.dip_met) begin
                                    phase_next = PH_END;
                                    if (stat.end_met) begin
                                        phase_next  = PH_FOUND;
                                        synced_next = 1'b1;
                                        pulse_end   = 1'b1;
                                    end
                                end
                            end
                            PH_END: begin
                                if (stat.end_timeout) begin
                                    cmd.clear_window = 1'b1;
                                    phase_next       = PH_FILL;
                                    pulse_to         = 1'b1;
                                end else if (stat.end_met) begin
                                    phase_next  = PH_FOUND;
                                    synced_next = 1'b1;
                                    pulse_end   = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    state_next = emit ? ST_IDLE : ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                // The mean level is loaded once the divider finishes.
                if (stat.div_done && can_emit) begin
                    cmd.level_load   = 1'b1;
                    cmd.clear_window = 1'b1;
                    phase_next       = PH_FILL;
                    emit             = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result register: loads a new transaction or drains on acceptance.
    always_comb begin
        m_valid_next   = m_valid_reg && !m_tready;
        out_phase_next = out_phase_reg;
        out_end_next   = out_end_reg;
        out_to_next    = out_to_reg;
        out_sync_next  = out_sync_reg;
        if (emit) begin
            m_valid_next   = 1'b1;
            out_phase_next = phase_next;
            out_end_next   = pulse_end;
            out_to_next    = pulse_to;
            out_sync_next  = synced_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_INIT;
            synced_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            synced_reg  <= synced_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_phase_reg <= out_phase_next;
        out_end_reg   <= out_end_next;
        out_to_reg    <= out_to_next;
        out_sync_reg  <= out_sync_next;
    end

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = m_valid_reg;
    assign m_phase     = out_phase_reg;
    assign m_null_end  = out_end_reg;
    assign m_timed_out = out_to_reg;
    assign m_synced    = out_sync_reg;

    // An accepted transaction always moves on to the update step.
    a_accept_to_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_UPDATE))
        else $error("accepted transaction did not enter the update step");

    // A result never reports a found end and a timeout together.
    a_end_or_timeout: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_end_reg && out_to_reg))
        else $error("null end and timeout flagged in one result");

    // A found end leaves the block synchronized and waiting.
    a_end_means_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_end_reg) |-> (out_sync_reg && (out_phase_reg == PH_FOUND)))
        else $error("null end reported without sync in the found phase");

endmodule

// ===== rtl/dab_null_symbol_detector.sv =====
// Top level of the DAB null symbol detector.
// Holds the configuration registers and joins controller and datapath.
// Depends on dnsd_pkg, dnsd_ctrl and dnsd_datapath.
//
// Usage: every input transaction carries one envelope magnitude, or a restart
// command when s_tuser is set. Each input transaction yields exactly one
// result transaction with the search phase, the null end and timeout pulses
// and the sync flag. The configuration port sets the symbol length (offset 0)
// and the null symbol length (offset 4); write it only while no transaction
// is in flight.
// Timing: a transaction goes through accept, update and threshold test before
// its result is presented; no new one is accepted until the last has left
// its test or divide step. The transaction that completes the initial level
// measurement also runs the mean divider, one quotient bit per cycle.
// Reset clears the level, sums and counters and returns to the initial
// measurement phase; the configuration registers return to 2552 and 2656.
// A stalled receiver holds the result register; the next transaction is
// still accepted and waits in its test step until the result is taken.
module dab_null_symbol_detector #(
    parameter int WINDOW_LEN   = dnsd_pkg::WINDOW_LEN_DEF,
    parameter int LEVEL_SHIFT  = dnsd_pkg::LEVEL_SHIFT_DEF,
    parameter int INIT_SYMBOLS = dnsd_pkg::INIT_SYMBOLS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input channel.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dnsd_pkg::SDATA_W-1:0] s_tdata,   // [15:0] magnitude
    input  logic [dnsd_pkg::SUSER_W-1:0] s_tuser,   // [0] func (1 = restart)
    // Result channel.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [dnsd_pkg::MDATA_W-1:0] m_tdata,   // [2:0] phase_code, [3] null_end,
                                                    // [4] timed_out, [5] synced, [7:6] zero
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dnsd_pkg::ADDR_W-1:0]  paddr,
    input  logic [dnsd_pkg::PDATA_W-1:0] pwdata,
    output logic [dnsd_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    import dnsd_pkg::*;

    logic [CFG_W-1:0]   sym_len_reg;
    logic [CFG_W-1:0]   null_len_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;
    dnsd_cmd_t          cmd;
    dnsd_stat_t         stat;
    logic [PHASE_W-1:0] out_phase;
    logic               out_end;
    logic               out_to;
    logic               out_sync;

    // Configuration registers; the word offset selects the register.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_len_reg  <= SYMBOL_LENGTH_RST;
            null_len_reg <= NULL_LENGTH_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SYMBOL_LENGTH: sym_len_reg  <= pwdata[CFG_W-1:0];
                REG_NULL_LENGTH:   null_len_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SYMBOL_LENGTH: prdata = PDATA_W'(sym_len_reg);
            REG_NULL_LENGTH:   prdata = PDATA_W'(null_len_reg);
            default:           prdata = '0;
        endcase
    end

    // Sequencing and phase control.
    dnsd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_phase     (out_phase),
        .m_null_end  (out_end),
        .m_timed_out (out_to),
        .m_synced    (out_sync),
        .cmd         (cmd),
        .stat        (stat)
    );

    // Level, window and threshold arithmetic.
    dnsd_datapath #(
        .WINDOW_LEN   (WINDOW_LEN),
        .LEVEL_SHIFT  (LEVEL_SHIFT),
        .INIT_SYMBOLS (INIT_SYMBOLS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .func_in       (s_tuser[0]),
        .mag_in        (s_tdata[MAG_W-1:0]),
        .symbol_length (sym_len_reg),
        .null_length   (null_len_reg),
        .cmd           (cmd),
        .stat          (stat)
    );

    assign m_tdata = {2'b00, out_sync, out_to, out_end, out_phase};

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for dab_null_symbol_detector: streams magnitude and
// restart transactions, predicts every status result and checks it in order.
// Depends on dnsd_pkg and the dab_null_symbol_detector RTL.
module testbench;
    import dnsd_pkg::*;

    typedef struct packed {
        phase_t phase;
        logic   null_end;
        logic   timed_out;
        logic   synced;
    } status_t;

    localparam logic              FUNC_SAMPLE        = 1'b0;
    localparam logic              FUNC_RESTART       = 1'b1;
    localparam logic [ADDR_W-1:0] ADDR_SYMBOL_LENGTH = {REG_SYMBOL_LENGTH, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_NULL_LENGTH   = {REG_NULL_LENGTH, 2'b00};

    localparam int          WIN          = WINDOW_LEN_DEF;
    localparam int          SHIFT        = LEVEL_SHIFT_DEF;
    localparam int          INIT_SYMS    = INIT_SYMBOLS_DEF;
    localparam logic [63:0] LEVEL_SAT    = (64'd1 << LEVEL_W) - 64'd1;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 64;
    localparam int          RANDOM_ITEMS = 620;

    // Ports of the block.
    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [SDATA_W-1:0] s_tdata  = '0;   // [15:0] magnitude
    logic [SUSER_W-1:0] s_tuser  = '0;   // [0] func
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [MDATA_W-1:0] m_tdata;         // [2:0] phase, [3] null_end, [4] timed_out,
                                         // [5] synced, [7:6] zero
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [ADDR_W-1:0]  paddr    = '0;
    logic [PDATA_W-1:0] pwdata   = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Predictor state, mirrors the detector after every accepted transaction.
    logic [CFG_W-1:0] sym_len    = SYMBOL_LENGTH_RST;
    logic [CFG_W-1:0] null_len   = NULL_LENGTH_RST;
    phase_t           mdl_phase  = PH_INIT;
    logic [63:0]      level_acc  = '0;
    logic [31:0]      init_sum   = '0;
    logic [31:0]      init_count = '0;
    logic [MAG_W-1:0] ring [0:63] = '{default: '0};
    logic [31:0]      win_total  = '0;
    logic [IDX_W-1:0] sample_idx = '0;
    logic [31:0]      dip_cnt    = '0;
    logic             sync_flag  = 1'b0;
    logic             end_pulse  = 1'b0;
    logic             to_pulse   = 1'b0;

    status_t pending_status [$];
    int      mismatches  = 0;
    int      items_sent  = 0;
    int      quiet_count = 0;
    int      gap_pct     = 0;
    int      stall_pct   = 0;
    int      stall_left  = 0;

    dab_null_symbol_detector u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Window mean at most half the long-term level.
    function automatic logic window_low();
        return ({32'd0, win_total} << (SHIFT + 1)) <= (64'(WIN) * level_acc);
    endfunction

    // Window mean at least three quarters of the long-term level.
    function automatic logic window_high();
        return ({32'd0, win_total} << (SHIFT + 2)) >= (64'(3 * WIN) * level_acc);
    endfunction

    function automatic void start_fill();
        mdl_phase  = PH_FILL;
        win_total  = '0;
        sample_idx = '0;
    endfunction

    function automatic void check_found();
        if (window_high()) begin
            mdl_phase = PH_FOUND;
            sync_flag = 1'b1;
            end_pulse = 1'b1;
        end
    endfunction

    function automatic void start_end_search();
        mdl_phase = PH_END;
        check_found();
    endfunction

    function automatic void start_dip_search();
        mdl_phase = PH_DIP;
        dip_cnt   = '0;
        sync_flag = 1'b0;
        if (window_low())
            start_end_search();
    endfunction

    // Replace the oldest window entry with the new magnitude.
    function automatic void slide_window(logic [MAG_W-1:0] mag);
        logic [5:0] pos;
        pos = 6'(32'(sample_idx) % WIN);
        win_total = win_total - 32'(ring[pos]) + 32'(mag);
        ring[pos] = mag;
        sample_idx = sample_idx + 1'b1;
    endfunction

    // Advance the detector state by one transaction and return its status.
    function automatic status_t next_status(logic func, logic [MAG_W-1:0] mag);
        logic [63:0] target;
        logic [63:0] mean;
        logic [63:0] nl;
        logic [5:0]  pos;
        end_pulse = 1'b0;
        to_pulse  = 1'b0;
        if (func == FUNC_RESTART) begin
            // A restart is ignored while the initial level is measured.
            if (mdl_phase != PH_INIT)
                start_fill();
        end else if (mdl_phase == PH_INIT) begin
            target = 64'(INIT_SYMS) * 64'(sym_len);
            init_sum = (init_sum > (32'hFFFF_FFFF - 32'(mag))) ? 32'hFFFF_FFFF
                                                                : init_sum + 32'(mag);
            init_count = init_count + 1;
            if ({32'd0, init_count} >= target) begin
                mean = ({32'd0, init_sum} << SHIFT) / {32'd0, init_count};
                level_acc = (mean > LEVEL_SAT) ? LEVEL_SAT : mean;
                start_fill();
            end
        end else begin
            nl = level_acc - (level_acc >> SHIFT) + 64'(mag);
            level_acc = (nl > LEVEL_SAT) ? LEVEL_SAT : nl;
            case (mdl_phase)
                PH_FILL: begin
                    pos = 6'(32'(sample_idx) % WIN);
                    ring[pos] = mag;
                    win_total = win_total + 32'(mag);
                    sample_idx = sample_idx + 1'b1;
                    if (32'(sample_idx) >= WIN)
                        start_dip_search();
                end
                PH_DIP: begin
                    slide_window(mag);
                    if (dip_cnt < 32'hFFFF)
                        dip_cnt = dip_cnt + 1;
                    if (dip_cnt > 2 * 32'(sym_len)) begin
                        to_pulse = 1'b1;
                        start_fill();
                    end else if (window_low()) begin
                        start_end_search();
                    end
                end
                PH_END: begin
                    slide_window(mag);
                    if (32'(sample_idx) > 2 * 32'(sym_len) + 32'(null_len)) begin
                        to_pulse = 1'b1;
                        start_fill();
                    end else begin
                        check_found();
                    end
                end
                default: ;
            endcase
        end
        return '{phase: mdl_phase, null_end: end_pulse, timed_out: to_pulse,
                 synced: sync_flag};
    endfunction

    // Current long-term level in magnitude units.
    function automatic int unsigned level_now();
        return int'(level_acc >> SHIFT);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s: expected %h, got %h", what, want, got);
    endtask

    // Send one transaction, with an optional idle burst before it.
    task automatic send_item(input logic func, input logic [MAG_W-1:0] mag);
        int gap;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                s_tdata  <= SDATA_W'($urandom);
                s_tuser  <= SUSER_W'($urandom);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= mag;
        s_tuser  <= func;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_status.push_back(next_status(func, mag));
        items_sent++;
    endtask

    // Send n samples drawn from [lo, hi], clipped to the magnitude range.
    task automatic send_span(input int n, input int unsigned lo, input int unsigned hi);
        int unsigned top;
        int unsigned bottom;
        top    = (hi > 32'hFFFF) ? 32'hFFFF : hi;
        bottom = (lo > top) ? top : lo;
        repeat (n)
            send_item(FUNC_SAMPLE, MAG_W'($urandom_range(bottom, top)));
    endtask

    // Drop the input valid and wait until every result has been taken.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Register write followed by a read back of the same register.
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (addr == ADDR_SYMBOL_LENGTH)
            sym_len = value[CFG_W-1:0];
        else
            null_len = value[CFG_W-1:0];
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata !== {{(PDATA_W-CFG_W){1'b0}}, value[CFG_W-1:0]})
            flag_mismatch("register read back", {19'd0, value[CFG_W-1:0]}, prdata);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One well-formed frame: restart, fill (mostly near the level), dip, recovery, random tail.
    task automatic send_search_frame();
        int unsigned lvl;
        lvl = level_now();
        if (lvl == 0)
            lvl = 1;
        send_item(FUNC_RESTART, MAG_W'($urandom));
        // Sometimes the window is already low when the fill completes.
        if ($urandom_range(0, 5) == 0)
            send_span(WIN, 0, lvl / 4);
        else
            send_span(WIN, lvl * 3 / 4, lvl * 5 / 4);
        send_span($urandom_range(10, 50), 0, lvl / 4);
        if ($urandom_range(0, 3) == 0)
            send_span($urandom_range(10, 40), 32'hFE00, 32'hFFFF);
        else
            send_span($urandom_range(10, 40), lvl, 2 * lvl);
        send_span($urandom_range(0, 5), 0, 32'hFFFF);
    endtask

    // Noise: raw magnitudes with stray restarts.
    task automatic send_noise_run();
        int n;
        n = $urandom_range(1, 60);
        repeat (n)
            send_item(($urandom_range(0, 19) == 0) ? FUNC_RESTART : FUNC_SAMPLE,
                      MAG_W'($urandom));
    endtask

    // Initial level: restart ignored, field extremes, then a zero-length init
    // that ends the measurement on the next sample.
    task automatic test_init_level();
        write_reg(ADDR_SYMBOL_LENGTH, 32'd1);
        write_reg(ADDR_NULL_LENGTH, 32'd64);
        send_item(FUNC_RESTART, 16'hFFFF);
        send_item(FUNC_SAMPLE, 16'h0000);
        send_item(FUNC_SAMPLE, 16'hFFFF);
        send_item(FUNC_SAMPLE, 16'h0001);
        send_item(FUNC_SAMPLE, 16'h8000);
        send_item(FUNC_SAMPLE, 16'h5555);
        send_item(FUNC_SAMPLE, 16'h2AAA);
        wait_idle();
        write_reg(ADDR_SYMBOL_LENGTH, 32'd0);
        send_item(FUNC_SAMPLE, 16'h3039);
    endtask

    // Restarts while the window fills clear it and start over.
    task automatic test_restart_in_fill();
        send_item(FUNC_SAMPLE, 16'h5555);
        send_item(FUNC_SAMPLE, 16'hAAAA);
        send_item(FUNC_RESTART, 16'h1234);
        send_item(FUNC_RESTART, 16'h0000);
        send_item(FUNC_SAMPLE, 16'h7FFF);
        send_item(FUNC_SAMPLE, 16'h0000);
        send_item(FUNC_SAMPLE, 16'hFFFF);
        send_item(FUNC_RESTART, 16'hFFFF);
    endtask

    // Search frames and noise under a series of register settings.
    task automatic test_search_frames();
        int          frame;
        int unsigned sym;
        int unsigned nul;
        logic [31:0] junk;
        frame = 0;
        while (items_sent < RANDOM_ITEMS) begin
            wait_idle();
            case (frame)
                0:       begin sym = 64;   nul = 64;   end
                1:       begin sym = 4096; nul = 4096; end
                2:       begin sym = 8191; nul = 8191; end
                3:       begin sym = 0;    nul = 0;    end
                4:       begin sym = 20;   nul = 0;    end
                5:       begin sym = 35;   nul = 150;  end
                default: begin
                    sym = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 60)
                                                      : $urandom_range(61, 8191);
                    nul = $urandom_range(0, 300);
                end
            endcase
            // Upper write data bits are not part of the register.
            junk = ($urandom_range(0, 3) == 0) ? ($urandom & ~32'h1FFF) : 32'd0;
            write_reg(ADDR_SYMBOL_LENGTH, junk | sym);
            write_reg(ADDR_NULL_LENGTH, junk | nul);
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 30;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                default: stall_pct = 30;
            endcase
            repeat (2) begin
                if ($urandom_range(0, 3) == 0)
                    send_noise_run();
                else
                    send_search_frame();
            end
            frame++;
        end
    endtask

    // Back-to-back stream at the reset settings, with no idling on either side.
    task automatic test_steady_stream();
        wait_idle();
        gap_pct   = 0;
        stall_pct = 0;
        write_reg(ADDR_SYMBOL_LENGTH, 32'(SYMBOL_LENGTH_RST));
        write_reg(ADDR_NULL_LENGTH, 32'(NULL_LENGTH_RST));
        send_search_frame();
        send_noise_run();
    endtask

    // Receiver readiness with random stall bursts.
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
                stall_left <= $urandom_range(1, 8);
        end
    end

    // Compare each result transaction with the oldest expected status.
    always @(posedge aclk) begin : check_results
        status_t want;
        string   bad;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_status.size() == 0) begin
                flag_mismatch("result with nothing expected", 32'd0, 32'(m_tdata));
            end else begin
                want = pending_status.pop_front();
                bad = "";
                if (m_tdata[2:0] !== want.phase)
                    bad = {bad, " phase_code"};
                if (m_tdata[3] !== want.null_end)
                    bad = {bad, " null_end"};
                if (m_tdata[4] !== want.timed_out)
                    bad = {bad, " timed_out"};
                if (m_tdata[5] !== want.synced)
                    bad = {bad, " synced"};
                if (m_tdata[7:6] !== 2'b00)
                    bad = {bad, " padding"};
                if (bad != "")
                    flag_mismatch({"result", bad},
                                  {24'd0, 2'b00, want.synced, want.timed_out,
                                   want.null_end, want.phase[2:0]},
                                  32'(m_tdata));
            end
        end
    end

    // Watchdog on cycles without any transaction on either channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_init_level();
        test_restart_in_fill();
        test_search_frames();
        test_steady_stream();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
